// ----- rtl/srdb_pkg.sv -----
// ----------------------------------------------------------------------------
// srdb_pkg
// Types and fixed sizes shared by the replacement policy controller and
// datapath.
// ----------------------------------------------------------------------------
package srdb_pkg;

	localparam int SET_W   = 11;
	localparam int WAY_W   = 4;
	localparam int NWAYS   = 16;
	localparam int SIG_W   = 11;
	localparam int HIST    = 4;
	localparam int HP_W    = 2;
	localparam int FILL_W  = 10;
	localparam int ADDR_W  = 48;
	localparam int DELTA_W = 49;
	localparam int NSETS   = 2048;
	localparam int NSIGS   = 2048;

	localparam logic [1:0] RRPV_FAR  = 2'd3;
	localparam logic [1:0] DEAD_FULL = 2'd3;
	localparam logic [1:0] CTR_MAX   = 2'd3;

	typedef struct packed {
		logic [1:0]       rrpv;
		logic [1:0]       dead;
		logic [SIG_W-1:0] sig;
	} line_ent_t;

	typedef line_ent_t [NWAYS-1:0] line_row_t;

	typedef struct packed {
		logic [ADDR_W-1:0]                last;
		logic [HIST-1:0][DELTA_W-1:0]     hist;
		logic [HP_W-1:0]                  ptr;
	} set_row_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_READ,
		ST_QUERY,
		ST_SET,
		ST_LINE,
		ST_ORD,
		ST_ODEC,
		ST_DRD,
		ST_DWR
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic vict;
		logic set_upd;
		logic line_upd;
		logic ord;
		logic odec;
		logic fill_adv;
		logic drd;
		logic dwr;
		logic clr;
	} srdb_cmd_t;

	typedef struct packed {
		logic is_query;
		logic is_hit;
		logic need_odec;
		logic fill_wrap;
		logic sweep_last;
		logic sweep_zero;
		logic out_free;
		logic out_valid;
	} srdb_sts_t;

endpackage

// ----- rtl/srdb_if.sv -----
// ----------------------------------------------------------------------------
// srdb_req_if / srdb_rsp_if
// Valid/ready channels for access items and victim results.
// ----------------------------------------------------------------------------
interface srdb_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [10:0] set_index;
	logic [3:0]  way_index;
	logic [47:0] address;
	logic [47:0] pc;
	logic        hit;
	logic        victim_valid;

	modport source (output valid, operation, set_index, way_index, address, pc, hit,
		victim_valid, input ready);
	modport sink (input valid, operation, set_index, way_index, address, pc, hit,
		victim_valid, output ready);
endinterface

interface srdb_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] victim_way;

	modport source (output valid, victim_way, input ready);
	modport sink (input valid, victim_way, output ready);
endinterface

// ----- rtl/srdb_dp.sv -----
// ----------------------------------------------------------------------------
// srdb_dp
// Datapath: line, set and signature-counter memories, item registers,
// victim search, stream detector and the output register.
// ----------------------------------------------------------------------------
module srdb_dp import srdb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  srdb_cmd_t         cmd,
	output srdb_sts_t         sts,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              operation,
	input  logic [SET_W-1:0]  set_index,
	input  logic [WAY_W-1:0]  way_index,
	input  logic [ADDR_W-1:0] address,
	input  logic [ADDR_W-1:0] pc,
	input  logic              hit,
	input  logic              victim_valid,
	output logic              out_valid,
	output logic [WAY_W-1:0]  victim_way,
	input  logic              out_ready
);

	line_row_t        line_mem [NSETS];
	set_row_t         set_mem [NSETS];
	logic [1:0]       sig_mem [NSIGS];

	line_row_t        line_rd_q;
	set_row_t         set_rd_q;
	logic [1:0]       sig_rd_q;

	logic             op_q, hit_q, vv_q, stream_q;
	logic [SET_W-1:0] set_q;
	logic [WAY_W-1:0] way_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIG_W-1:0] sig_q, old_sig_q;
	logic [SET_W-1:0] sweep_q;
	logic [FILL_W-1:0] fill_q;
	logic [1:0]       thr_q;
	logic             out_valid_q;
	logic [WAY_W-1:0] victim_q;

	// Latch the item and its signature
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			set_q  <= set_index;
			way_q  <= way_index;
			addr_q <= address;
			hit_q  <= hit;
			vv_q   <= victim_valid;
			sig_q  <= pc[SIG_W-1:0] ^ pc[SIG_W+5:6];
		end
	end

	// Threshold, fill counter, sweep counter, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= 2'd3;
			fill_q      <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				thr_q <= cfg_wdata;
			if (cmd.fill_adv)
				fill_q <= fill_q + 1'b1;
			if (cmd.clr || cmd.dwr)
				sweep_q <= sweep_q + 1'b1;
			if (cmd.vict)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Victim search: first saturated dead counter, else age to distant
	logic             dead_found, rrpv_found;
	logic [WAY_W-1:0] dead_way, rrpv_way;
	logic [1:0]       top, age;
	line_row_t        aged_row;

	always_comb begin
		dead_found = 1'b0;
		dead_way   = '0;
		rrpv_found = 1'b0;
		rrpv_way   = '0;
		top        = 2'd0;
		for (int w = 0; w < NWAYS; w++)
			top[1] = top[1] | line_rd_q[w].rrpv[1];
		for (int w = 0; w < NWAYS; w++)
			if (line_rd_q[w].rrpv[1] == top[1])
				top[0] = top[0] | line_rd_q[w].rrpv[0];
		age      = RRPV_FAR - top;
		aged_row = line_rd_q;
		for (int w = 0; w < NWAYS; w++)
			aged_row[w].rrpv = line_rd_q[w].rrpv + age;
		for (int w = NWAYS - 1; w >= 0; w--) begin
			if (line_rd_q[w].dead == DEAD_FULL) begin
				dead_found = 1'b1;
				dead_way   = WAY_W'(w);
			end
			if (aged_row[w].rrpv == RRPV_FAR) begin
				rrpv_found = 1'b1;
				rrpv_way   = WAY_W'(w);
			end
		end
		if (!rrpv_found)
			rrpv_way = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.vict)
			victim_q <= dead_found ? dead_way : rrpv_way;
	end

	// Stream detector on the set row
	logic [DELTA_W-1:0]            delta;
	logic [HIST-1:0][DELTA_W-1:0]  hist_n;
	logic [1:0]                    match;
	set_row_t                      set_wr_row;

	always_comb begin
		delta = '0;
		if (set_rd_q.last != '0)
			delta = {1'b0, addr_q} - {1'b0, set_rd_q.last};
		hist_n = set_rd_q.hist;
		hist_n[set_rd_q.ptr] = delta;
		match = 2'd0;
		for (int i = 1; i < HIST; i++)
			if (hist_n[0] != '0 && hist_n[i] == hist_n[0])
				match = match + 2'd1;
		set_wr_row.last = addr_q;
		set_wr_row.hist = hist_n;
		set_wr_row.ptr  = set_rd_q.ptr + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.set_upd)
			stream_q <= (match >= thr_q);
		if (cmd.line_upd)
			old_sig_q <= line_rd_q[way_q].sig;
	end

	// Line update for a hit or a fill; dead-counter decay
	line_row_t upd_row, decay_row;

	always_comb begin
		upd_row = line_rd_q;
		if (hit_q) begin
			upd_row[way_q].rrpv = 2'd0;
			upd_row[way_q].dead = 2'd0;
		end else begin
			upd_row[way_q].rrpv = (!stream_q && sig_rd_q >= 2'd2) ? RRPV_FAR - 2'd1
				: RRPV_FAR;
			upd_row[way_q].sig  = sig_q;
			upd_row[way_q].dead = vv_q ? 2'd1 : 2'd0;
		end
		decay_row = line_rd_q;
		for (int w = 0; w < NWAYS; w++)
			if (line_rd_q[w].dead != 2'd0)
				decay_row[w].dead = line_rd_q[w].dead - 2'd1;
	end

	// Line memory port
	logic             line_we;
	logic [SET_W-1:0] line_wa, line_ra;
	line_row_t        line_wd, clr_row;

	always_comb begin
		for (int w = 0; w < NWAYS; w++) begin
			clr_row[w].rrpv = RRPV_FAR;
			clr_row[w].dead = 2'd0;
			clr_row[w].sig  = '0;
		end
		line_we = cmd.clr | cmd.dwr | cmd.line_upd | (cmd.vict & ~dead_found);
		line_wa = (cmd.clr | cmd.dwr) ? sweep_q : set_q;
		line_ra = cmd.drd ? sweep_q : set_q;
		if (cmd.clr)
			line_wd = clr_row;
		else if (cmd.dwr)
			line_wd = decay_row;
		else if (cmd.line_upd)
			line_wd = upd_row;
		else
			line_wd = aged_row;
	end

	always_ff @(posedge clk) begin
		if (line_we)
			line_mem[line_wa] <= line_wd;
		if (cmd.rd || cmd.drd)
			line_rd_q <= line_mem[line_ra];
	end

	// Set memory port
	always_ff @(posedge clk) begin
		if (cmd.clr)
			set_mem[sweep_q] <= '0;
		else if (cmd.set_upd)
			set_mem[set_q] <= set_wr_row;
		if (cmd.rd)
			set_rd_q <= set_mem[set_q];
	end

	// Signature counter memory port
	logic             sig_we;
	logic [SIG_W-1:0] sig_wa, sig_ra;
	logic [1:0]       sig_wd;

	always_comb begin
		sig_we = cmd.clr | (cmd.line_upd & hit_q) | cmd.odec;
		sig_ra = cmd.ord ? old_sig_q : sig_q;
		if (cmd.clr) begin
			sig_wa = sweep_q;
			sig_wd = 2'd1;
		end else if (cmd.odec) begin
			sig_wa = old_sig_q;
			sig_wd = (sig_rd_q != 2'd0) ? sig_rd_q - 2'd1 : sig_rd_q;
		end else begin
			sig_wa = sig_q;
			sig_wd = (sig_rd_q < CTR_MAX) ? sig_rd_q + 2'd1 : sig_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sig_we)
			sig_mem[sig_wa] <= sig_wd;
		if (cmd.rd || cmd.ord)
			sig_rd_q <= sig_mem[sig_ra];
	end

	// Status toward the controller
	always_comb begin
		sts.is_query   = ~op_q;
		sts.is_hit     = hit_q;
		sts.need_odec  = vv_q & (line_rd_q[way_q].rrpv == RRPV_FAR);
		sts.fill_wrap  = &fill_q;
		sts.sweep_last = &sweep_q;
		sts.sweep_zero = (sweep_q == '0);
		sts.out_free   = ~out_valid_q | out_ready;
		sts.out_valid  = out_valid_q;
	end

	assign out_valid  = out_valid_q;
	assign victim_way = victim_q;

endmodule

// ----- rtl/srdb_ctrl.sv -----
// ----------------------------------------------------------------------------
// srdb_ctrl
// Controller: sequences memory reads, updates, the clearing pass after
// reset and the periodic dead-counter decay sweep.
// ----------------------------------------------------------------------------
module srdb_ctrl import srdb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  srdb_sts_t sts,
	output srdb_cmd_t cmd
);

	state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLR;
		else
			state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (sts.sweep_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = sts.is_query ? ST_QUERY : ST_SET;
			end
			ST_QUERY: begin
				if (sts.out_free) begin
					cmd.vict = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SET: begin
				cmd.set_upd = 1'b1;
				state_d     = ST_LINE;
			end
			ST_LINE: begin
				cmd.line_upd = 1'b1;
				if (sts.is_hit)
					state_d = ST_IDLE;
				else if (sts.need_odec)
					state_d = ST_ORD;
				else begin
					cmd.fill_adv = 1'b1;
					state_d = sts.fill_wrap ? ST_DRD : ST_IDLE;
				end
			end
			ST_ORD: begin
				cmd.ord = 1'b1;
				state_d = ST_ODEC;
			end
			ST_ODEC: begin
				cmd.odec     = 1'b1;
				cmd.fill_adv = 1'b1;
				state_d = sts.fill_wrap ? ST_DRD : ST_IDLE;
			end
			ST_DRD: begin
				cmd.drd = 1'b1;
				state_d = ST_DWR;
			end
			ST_DWR: begin
				cmd.dwr = 1'b1;
				state_d = sts.sweep_last ? ST_IDLE : ST_DRD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_idle_sweep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> sts.sweep_zero)
		else $error("sweep counter not at rest while idle");
	a_vict_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.vict |=> sts.out_valid)
		else $error("victim beat not presented");
	a_odec_after_ord: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ODEC |-> $past(state_q == ST_ORD))
		else $error("counter decrement without read");
`endif

endmodule

// ----- rtl/ship_rrip_dead_block_replacement.sv -----
// ----------------------------------------------------------------------------
// ship_rrip_dead_block_replacement
// Cache replacement policy: RRIP with signature insertion, dead-block
// counters and a per-set stream detector.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per access: a victim query (operation 0) or an
//   access update (operation 1). rsp returns one victim_way beat per query;
//   updates return nothing. cfg_we writes the stream match threshold.
//   A query reads the memories, then loads its result into the output
//   register and writes the aged line row back when no dead way is found.
//   An update reads them, then writes the set row and then the line row; a
//   hit also raises its signature counter, and a fill over a valid line at
//   distant re-reference also decrements that line's signature counter.
//   Every 1024th fill adds a decay sweep over each set of the line memory.
//   After reset a clearing pass over all 2048 sets initializes the memories;
//   req stays not ready meanwhile. A query result waits in the output
//   register while rsp is stalled; the next item is taken meanwhile and a
//   following query holds until that register frees.
// ----------------------------------------------------------------------------
module ship_rrip_dead_block_replacement import srdb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	srdb_req_if.sink   req,
	srdb_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);

	srdb_cmd_t cmd;
	srdb_sts_t sts;
	logic      in_ready;

	assign req.ready = in_ready;

	srdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srdb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.operation    (req.operation),
		.set_index    (req.set_index),
		.way_index    (req.way_index),
		.address      (req.address),
		.pc           (req.pc),
		.hit          (req.hit),
		.victim_valid (req.victim_valid),
		.out_valid    (rsp.valid),
		.victim_way   (rsp.victim_way),
		.out_ready    (rsp.ready)
	);

endmodule
